// ===== rtl/core/jsp_pkg.sv =====
`timescale 1ns / 1ps

package jsp_pkg;

    // Widths of the document counter, the size register and the depth counters.
    localparam int unsigned COUNT_W = 25;
    localparam int unsigned DEPTH_W = 16;

    // Saturation value of the byte counter and reset value of the size limit.
    localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] MAX_DOC_RESET = COUNT_W'(1024 * 1024);

    // Nesting limit; a depth that would pass it saturates and flags overflow.
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 16'd65535;

    // Byte values that matter to the structure check.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // Depth of the token queue between the front and the back.
    localparam int unsigned TOKQ_DEPTH = 4;
    localparam int unsigned TOKQ_AW    = $clog2(TOKQ_DEPTH);

    // Byte class produced by the front.
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_LBRACE,
        CLS_RBRACE,
        CLS_LBRACK,
        CLS_RBRACK,
        CLS_QUOTE,
        CLS_BSLASH
    } t_cls;

    // Verdict codes.
    typedef enum logic [2:0] {
        FAIL_OK        = 3'd0,
        FAIL_TOO_LARGE = 3'd1,
        FAIL_NO_KEY    = 3'd2,
        FAIL_UNDERFLOW = 3'd3,
        FAIL_UNBALANCE = 3'd4
    } t_fail;

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        t_cls cls;
        logic last;
        logic key_hit;
    } t_tok;

endpackage

// ===== rtl/core/jsp_front.sv =====
`timescale 1ns / 1ps

module jsp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_text_byte,
    input  logic          i_end_of_doc,
    output jsp_pkg::t_tok o_tok
);

    logic [2:0] r_key_pos;
    logic [2:0] n_key_pos;
    logic       r_key_seen;
    logic       n_key_seen;
    logic [7:0] key_byte;

    // Expected byte at each position of the quoted key "jobs".
    always_comb begin
        case (r_key_pos)
            3'd0:    key_byte = jsp_pkg::CH_QUOTE;
            3'd1:    key_byte = 8'h6A;
            3'd2:    key_byte = 8'h6F;
            3'd3:    key_byte = 8'h62;
            3'd4:    key_byte = 8'h73;
            3'd5:    key_byte = jsp_pkg::CH_QUOTE;
            default: key_byte = jsp_pkg::CH_QUOTE;
        endcase
    end

    // Key matcher; the closing quote of a match may open the next one.
    always_comb begin
        n_key_seen = r_key_seen;
        if (i_text_byte == key_byte) begin
            if (r_key_pos >= 3'd5) begin
                n_key_pos  = 3'd1;
                n_key_seen = 1'b1;
            end else begin
                n_key_pos = r_key_pos + 3'd1;
            end
        end else if (i_text_byte == jsp_pkg::CH_QUOTE) begin
            n_key_pos = 3'd1;
        end else begin
            n_key_pos = 3'd0;
        end
    end

    // Byte classification.
    always_comb begin
        case (i_text_byte)
            jsp_pkg::CH_LBRACE: o_tok.cls = jsp_pkg::CLS_LBRACE;
            jsp_pkg::CH_RBRACE: o_tok.cls = jsp_pkg::CLS_RBRACE;
            jsp_pkg::CH_LBRACK: o_tok.cls = jsp_pkg::CLS_LBRACK;
            jsp_pkg::CH_RBRACK: o_tok.cls = jsp_pkg::CLS_RBRACK;
            jsp_pkg::CH_QUOTE:  o_tok.cls = jsp_pkg::CLS_QUOTE;
            jsp_pkg::CH_BSLASH: o_tok.cls = jsp_pkg::CLS_BSLASH;
            default:            o_tok.cls = jsp_pkg::CLS_OTHER;
        endcase
        o_tok.last    = i_end_of_doc;
        o_tok.key_hit = n_key_seen;
    end

    // Matcher state restarts after the final byte of each document.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pos  <= 3'd0;
            r_key_seen <= 1'b0;
        end else if (i_accept) begin
            if (i_end_of_doc) begin
                r_key_pos  <= 3'd0;
                r_key_seen <= 1'b0;
            end else begin
                r_key_pos  <= n_key_pos;
                r_key_seen <= n_key_seen;
            end
        end
    end

endmodule

// ===== rtl/core/jsp_tok_fifo.sv =====
`timescale 1ns / 1ps

module jsp_tok_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  jsp_pkg::t_tok i_wr_tok,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_vld,
    output jsp_pkg::t_tok o_rd_tok
);

    jsp_pkg::t_tok                  r_mem [jsp_pkg::TOKQ_DEPTH];
    logic [jsp_pkg::TOKQ_AW-1:0]    r_wr_ptr;
    logic [jsp_pkg::TOKQ_AW-1:0]    r_rd_ptr;
    logic [jsp_pkg::TOKQ_AW:0]      r_cnt;
    logic                           wr_en;
    logic                           rd_en;

    assign o_full   = (r_cnt == (jsp_pkg::TOKQ_AW+1)'(jsp_pkg::TOKQ_DEPTH));
    assign o_vld    = (r_cnt != '0);
    assign o_rd_tok = r_mem[r_rd_ptr];
    assign wr_en    = i_wr && !o_full;
    assign rd_en    = i_rd && o_vld;

    // Token storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_tok;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/jsp_back.sv =====
`timescale 1ns / 1ps

module jsp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr,
    input  logic [jsp_pkg::COUNT_W-1:0]  i_cfg_data,
    input  logic                         i_tok_vld,
    input  jsp_pkg::t_tok                i_tok,
    output logic                         o_tok_rd,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic                         o_doc_ok,
    output logic [2:0]                   o_fail_code
);

    logic [jsp_pkg::COUNT_W-1:0] r_max_doc;

    logic [jsp_pkg::COUNT_W-1:0] r_total;
    logic [jsp_pkg::COUNT_W-1:0] n_total;
    logic                        r_str;
    logic                        n_str;
    logic                        r_esc;
    logic                        n_esc;
    logic [jsp_pkg::DEPTH_W-1:0] r_brace;
    logic [jsp_pkg::DEPTH_W-1:0] n_brace;
    logic [jsp_pkg::DEPTH_W-1:0] r_brack;
    logic [jsp_pkg::DEPTH_W-1:0] n_brack;
    logic                        r_unf;
    logic                        n_unf;
    logic                        r_ovf;
    logic                        n_ovf;

    jsp_pkg::t_fail              code;

    // Two-entry result queue: head is shown on the ports, tail waits behind it.
    logic                        r_h_vld;
    jsp_pkg::t_fail              r_h_code;
    logic                        r_t_vld;
    jsp_pkg::t_fail              r_t_code;
    logic                        pop_en;
    logic                        res_wr;
    logic                        h_vld_aft;
    jsp_pkg::t_fail              h_code_aft;

    // A token is taken unless it is a final byte and the result queue is full.
    assign o_tok_rd = i_tok_vld && (!i_tok.last || !r_t_vld);
    assign res_wr   = o_tok_rd && i_tok.last;
    assign pop_en   = i_pop && r_h_vld;

    // Size limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_doc <= jsp_pkg::MAX_DOC_RESET;
        end else if (i_cfg_wr) begin
            r_max_doc <= i_cfg_data;
        end
    end

    // Per-byte update of the string, escape and depth tracking.
    always_comb begin
        n_total = (r_total != jsp_pkg::COUNT_MAX) ? r_total + 1'b1 : r_total;
        n_str   = r_str;
        n_esc   = r_esc;
        n_brace = r_brace;
        n_brack = r_brack;
        n_unf   = r_unf;
        n_ovf   = r_ovf;
        if (r_esc) begin
            n_esc = 1'b0;
        end else if (i_tok.cls == jsp_pkg::CLS_BSLASH && r_str) begin
            n_esc = 1'b1;
        end else if (i_tok.cls == jsp_pkg::CLS_QUOTE) begin
            n_str = !r_str;
        end else if (!r_str && !r_unf) begin
            case (i_tok.cls)
                jsp_pkg::CLS_LBRACE: begin
                    if (r_brace >= jsp_pkg::DEPTH_LIMIT) begin
                        n_brace = jsp_pkg::DEPTH_LIMIT;
                        n_ovf   = 1'b1;
                    end else begin
                        n_brace = r_brace + 1'b1;
                    end
                end
                jsp_pkg::CLS_RBRACE: begin
                    if (r_brace == '0) begin
                        n_unf = 1'b1;
                    end else begin
                        n_brace = r_brace - 1'b1;
                    end
                end
                jsp_pkg::CLS_LBRACK: begin
                    if (r_brack >= jsp_pkg::DEPTH_LIMIT) begin
                        n_brack = jsp_pkg::DEPTH_LIMIT;
                        n_ovf   = 1'b1;
                    end else begin
                        n_brack = r_brack + 1'b1;
                    end
                end
                jsp_pkg::CLS_RBRACK: begin
                    if (r_brack == '0) begin
                        n_unf = 1'b1;
                    end else begin
                        n_brack = r_brack - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Verdict on the final byte, first failing check wins.
    always_comb begin
        if (n_total > r_max_doc) begin
            code = jsp_pkg::FAIL_TOO_LARGE;
        end else if (!i_tok.key_hit) begin
            code = jsp_pkg::FAIL_NO_KEY;
        end else if (n_unf) begin
            code = jsp_pkg::FAIL_UNDERFLOW;
        end else if (n_ovf || n_brace != '0 || n_brack != '0 || n_str) begin
            code = jsp_pkg::FAIL_UNBALANCE;
        end else begin
            code = jsp_pkg::FAIL_OK;
        end
    end

    // Document state; everything returns to zero after the final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_str   <= 1'b0;
            r_esc   <= 1'b0;
            r_brace <= '0;
            r_brack <= '0;
            r_unf   <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (o_tok_rd) begin
            if (i_tok.last) begin
                r_total <= '0;
                r_str   <= 1'b0;
                r_esc   <= 1'b0;
                r_brace <= '0;
                r_brack <= '0;
                r_unf   <= 1'b0;
                r_ovf   <= 1'b0;
            end else begin
                r_total <= n_total;
                r_str   <= n_str;
                r_esc   <= n_esc;
                r_brace <= n_brace;
                r_brack <= n_brack;
                r_unf   <= n_unf;
                r_ovf   <= n_ovf;
            end
        end
    end

    // Result queue contents once the current pop has been applied.
    always_comb begin
        h_vld_aft  = pop_en ? r_t_vld : r_h_vld;
        h_code_aft = pop_en ? r_t_code : r_h_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
            r_t_vld <= 1'b0;
        end else begin
            r_h_vld <= h_vld_aft || res_wr;
            r_t_vld <= (pop_en ? 1'b0 : r_t_vld) || (res_wr && h_vld_aft);
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_wr && !h_vld_aft) begin
            r_h_code <= code;
        end else begin
            r_h_code <= h_code_aft;
        end
        if (res_wr && h_vld_aft) begin
            r_t_code <= code;
        end
    end

    assign o_empty     = !r_h_vld;
    assign o_fail_code = r_h_code;
    assign o_doc_ok    = (r_h_code == jsp_pkg::FAIL_OK);

endmodule

// ===== rtl/core/json_structure_prechecker_core.sv =====
`timescale 1ns / 1ps

// Structure precheck for a JSON document fed one byte per request, the final
// byte marked by i_end_of_doc. The block takes one byte every cycle while full
// is low; a front stage classifies each byte and runs the match for the quoted
// key "jobs", a four-entry token queue decouples it from the back stage, which
// tracks string, escape and brace/bracket depth state. One verdict per
// document (doc_ok and fail_code) appears on the result ports after the final
// byte is registered in the token queue and then in a
// two-entry result queue, so input keeps flowing while up to two
// verdicts wait to be popped. Checks are ranked: too large, key missing,
// underflow, then unbalanced or open string. The size limit is written through
// the cfg channel, which is always ready and should only be used between
// documents.
module json_structure_prechecker_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [jsp_pkg::COUNT_W-1:0] i_cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_text_byte,
    input  logic                        i_end_of_doc,
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_doc_ok,
    output logic [2:0]                  o_fail_code
);

    logic          in_accept;
    jsp_pkg::t_tok front_tok;
    jsp_pkg::t_tok back_tok;
    logic          tok_vld;
    logic          tok_rd;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = push && !full;

    // Front: classification and key match.
    jsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_text_byte  (i_text_byte),
        .i_end_of_doc (i_end_of_doc),
        .o_tok        (front_tok)
    );

    // Token queue between front and back.
    jsp_tok_fifo u_tok_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (push),
        .i_wr_tok (front_tok),
        .o_full   (full),
        .i_rd     (tok_rd),
        .o_vld    (tok_vld),
        .o_rd_tok (back_tok)
    );

    // Back: structure tracking, verdict and result queue.
    jsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_tok_vld   (tok_vld),
        .i_tok       (back_tok),
        .o_tok_rd    (tok_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_doc_ok    (o_doc_ok),
        .o_fail_code (o_fail_code)
    );

endmodule

// ===== tb/sv/json_structure_prechecker_core_test.sv =====
`timescale 1ns / 1ps

module json_structure_prechecker_core_test;

    import jsp_pkg::*;

    // Run control.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_BYTES   = 250;
    localparam int RANDOM_DOCS    = 10;
    localparam int DOCS_PER_LIMIT = 4;

    // Largest size limit the register is meant to hold.
    localparam logic [COUNT_W-1:0] SIZE_LIMIT_TOP = COUNT_W'(16777216);

    // The quoted key, opening quote in the top byte.
    localparam logic [47:0] JOBS_KEY = {CH_QUOTE, "jobs", CH_QUOTE};

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_byte_req;

    typedef struct packed {
        logic  ok;
        t_fail code;
    } t_verdict;

    // Block ports.
    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_valid  = 1'b0;
    logic               o_cfg_ready;
    logic [COUNT_W-1:0] i_cfg_data   = '0;
    logic               push         = 1'b0;
    logic               full;
    logic [7:0]         i_text_byte  = 8'h00;
    logic               i_end_of_doc = 1'b0;
    logic               empty;
    logic               pop          = 1'b0;
    logic               o_doc_ok;
    logic [2:0]         o_fail_code;

    // Stimulus and expected verdicts.
    t_byte_req  byte_reqs[$];
    t_verdict   verdicts_due[$];
    logic [7:0] doc_buf[$];
    int         bytes_queued = 0;
    int         bytes_taken  = 0;
    int         mismatches   = 0;
    int         quiet_cycles = 0;

    // Predictor state: a copy of the size register and the per-document trackers.
    logic [COUNT_W-1:0] size_limit = MAX_DOC_RESET;
    logic [COUNT_W-1:0] doc_bytes  = '0;
    logic               in_str     = 1'b0;
    logic               esc        = 1'b0;
    logic [DEPTH_W-1:0] brace_lvl  = '0;
    logic [DEPTH_W-1:0] brack_lvl  = '0;
    int                 key_pos    = 0;
    logic               key_found  = 1'b0;
    logic               underflow  = 1'b0;
    logic               overflow   = 1'b0;

    // Driver and monitor working variables.
    t_byte_req next_req;
    t_verdict  want;
    int        burst_left = 0;
    int        gap_left   = 0;
    int        stall_tick = 0;

    json_structure_prechecker_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_text_byte  (i_text_byte),
        .i_end_of_doc (i_end_of_doc),
        .empty        (empty),
        .pop          (pop),
        .o_doc_ok     (o_doc_ok),
        .o_fail_code  (o_fail_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatches++;
        $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
    endtask

    // One more nesting level, saturating at the limit.
    function automatic logic [DEPTH_W-1:0] deeper(input logic [DEPTH_W-1:0] lvl);
        if (lvl >= DEPTH_LIMIT) begin
            overflow = 1'b1;
            return DEPTH_LIMIT;
        end
        return lvl + 1'b1;
    endfunction

    // One level less; a close at depth zero marks underflow.
    function automatic logic [DEPTH_W-1:0] shallower(input logic [DEPTH_W-1:0] lvl);
        if (lvl == '0) begin
            underflow = 1'b1;
            return lvl;
        end
        return lvl - 1'b1;
    endfunction

    // Track one accepted byte and, on the final byte, queue the verdict.
    task automatic scan_byte(input logic [7:0] c, input logic last);
        t_verdict v;
        if (doc_bytes != COUNT_MAX) doc_bytes++;

        // The key search runs over every byte, strings included.
        if (key_pos > 5) key_pos = 0;
        if (c == JOBS_KEY[47 - 8 * key_pos -: 8]) begin
            key_pos++;
            if (key_pos == 6) begin
                key_found = 1'b1;
                key_pos   = 1;
            end
        end else begin
            key_pos = (c == CH_QUOTE) ? 1 : 0;
        end

        if (esc) begin
            esc = 1'b0;
        end else if (c == CH_BSLASH && in_str) begin
            esc = 1'b1;
        end else if (c == CH_QUOTE) begin
            in_str = !in_str;
        end else if (!in_str && !underflow) begin
            case (c)
                CH_LBRACE: brace_lvl = deeper(brace_lvl);
                CH_RBRACE: brace_lvl = shallower(brace_lvl);
                CH_LBRACK: brack_lvl = deeper(brack_lvl);
                CH_RBRACK: brack_lvl = shallower(brack_lvl);
                default: ;
            endcase
        end

        if (last) begin
            if (doc_bytes > size_limit) v.code = FAIL_TOO_LARGE;
            else if (!key_found) v.code = FAIL_NO_KEY;
            else if (underflow) v.code = FAIL_UNDERFLOW;
            else if (overflow || brace_lvl != '0 || brack_lvl != '0 || in_str) begin
                v.code = FAIL_UNBALANCE;
            end else v.code = FAIL_OK;
            v.ok = (v.code == FAIL_OK);
            verdicts_due.insert(verdicts_due.size(), v);
            doc_bytes = '0;
            in_str    = 1'b0;
            esc       = 1'b0;
            brace_lvl = '0;
            brack_lvl = '0;
            key_pos   = 0;
            key_found = 1'b0;
            underflow = 1'b0;
            overflow  = 1'b0;
        end
    endtask

    // Sender: bursts of random length separated by random gaps, some of them zero.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                bytes_taken++;
                scan_byte(i_text_byte, i_end_of_doc);
            end
            if (!push || !full) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (byte_reqs.size() != 0) begin
                    next_req = byte_reqs.pop_front();
                    push         <= 1'b1;
                    i_text_byte  <= next_req.b;
                    i_end_of_doc <= next_req.last;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each popped verdict and stalls in rotating windows of
    // full speed, random, sparse and long-stall patterns.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch("verdict with no document pending", o_fail_code, -1);
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_doc_ok !== want.ok) begin
                        report_mismatch("doc_ok", o_doc_ok, want.ok);
                    end
                    if (o_fail_code !== want.code) begin
                        report_mismatch("fail_code", o_fail_code, want.code);
                    end
                end
            end
            stall_tick++;
            case ((stall_tick / 64) % 4)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 1);
                2: pop <= (stall_tick % 8 == 0);
                default: pop <= (stall_tick % 64 >= 32);
            endcase
        end
    end

    // Watchdog: cycles in which no request of any kind is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Document building.
    task automatic append_byte(input logic [7:0] c);
        doc_buf.insert(doc_buf.size(), c);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) append_byte(s[i]);
    endtask

    task automatic commit_doc();
        t_byte_req r;
        if (doc_buf.size() == 0) append_byte("x");
        for (int i = 0; i < doc_buf.size(); i++) begin
            r.b    = doc_buf[i];
            r.last = (i == doc_buf.size() - 1);
            byte_reqs.insert(byte_reqs.size(), r);
        end
        bytes_queued += doc_buf.size();
        doc_buf.delete();
    endtask

    task automatic send_str(input string s);
        put_str(s);
        commit_doc();
    endtask

    // Any byte, with the structural characters favored.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 11))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_LBRACE;
            3: return CH_RBRACE;
            4: return CH_LBRACK;
            5: return CH_RBRACK;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        string pool;
        pool = "0123456789abcdefjos,: -";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    // A quoted string with random content and escapes.
    task automatic put_string_token();
        logic [7:0] c;
        append_byte(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 5) == 0) begin
                append_byte(CH_BSLASH);
                append_byte(noise_byte());
            end else begin
                c = noise_byte();
                if (c == CH_QUOTE || c == CH_BSLASH) c = "a";
                append_byte(c);
            end
        end
        append_byte(CH_QUOTE);
    endtask

    // Mostly well-formed objects with random content; some noise and damage.
    task automatic make_random_doc();
        logic [7:0] closers[$];
        int pos;
        doc_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10)) append_byte(noise_byte());
            return;
        end
        append_byte(CH_LBRACE);
        closers.insert(closers.size(), CH_RBRACE);
        if ($urandom_range(0, 4) != 0) put_str("\"jobs\":");
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 5))
                0: if (closers.size() < 5) begin
                    append_byte(CH_LBRACE);
                    closers.insert(closers.size(), CH_RBRACE);
                end
                1: if (closers.size() < 5) begin
                    append_byte(CH_LBRACK);
                    closers.insert(closers.size(), CH_RBRACK);
                end
                2: if (closers.size() > 1) append_byte(closers.pop_back());
                3: put_string_token();
                4: repeat ($urandom_range(1, 3)) append_byte(plain_byte());
                default: begin
                    case ($urandom_range(0, 4))
                        0: put_str("\"jobs\"");
                        1: put_str("\"job");
                        2: put_str("jobs\"");
                        3: put_str("\"\"jobs\"");
                        default: put_str("\"jobs\"jobs\"");
                    endcase
                end
            endcase
        end
        while (closers.size() != 0) append_byte(closers.pop_back());

        // Damage a share of the documents.
        pos = $urandom_range(0, doc_buf.size() - 1);
        case ($urandom_range(0, 9))
            0: doc_buf.insert(pos, noise_byte());
            1: if (doc_buf.size() > 1) doc_buf.delete(pos);
            2: doc_buf[pos] = noise_byte();
            3: doc_buf.push_front(($urandom_range(0, 1) == 1) ? CH_RBRACE : CH_RBRACK);
            4: if (doc_buf.size() > 1) doc_buf.delete(doc_buf.size() - 1);
            default: ;
        endcase
    endtask

    // Wait until every byte is taken and every verdict popped, then let the
    // pipeline settle.
    task automatic drain();
        while (bytes_taken != bytes_queued) @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        size_limit = value;
    endtask

    function automatic logic [COUNT_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return COUNT_W'(1);
            1: return SIZE_LIMIT_TOP;
            2: return MAX_DOC_RESET;
            default: return COUNT_W'($urandom_range(4, 40));
        endcase
    endfunction

    // Test sequence.
    initial begin
        int docs;
        int random_start;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed documents under the reset size limit.
        send_str("{\"jobs\":[1,2]}");
        send_str("{\"name\":\"x\"}");
        send_str("}{\"jobs\":1}");
        send_str("{\"jobs\":1}]{{[");
        send_str("{\"jobs\":[1}");
        send_str("{\"jobs\":\"a");
        send_str("{\"jobs\":\"\\\"}\\\\\"}");
        send_str("{\"k\":\"jobs\"}");
        send_str("\"\"jobs\"{}");
        send_str("{}\"jobs\"");
        send_str("\"jobs\"\\\"");
        send_str("\"jobs\"[\"\\");
        send_str("[[[{\"jobs\":{}}]]]");
        append_byte(8'h00);
        commit_doc();
        append_byte(8'hFF);
        commit_doc();
        put_str("{\"jobs\":\"");
        append_byte(8'hA5);
        append_byte(8'h7F);
        put_str("\"}");
        commit_doc();

        // Smallest size limit.
        drain();
        write_limit(COUNT_W'(1));
        send_str("x");
        send_str("{}");

        // A limit that an eight-byte document just meets.
        drain();
        write_limit(COUNT_W'(8));
        send_str("{\"jobs\"}");
        send_str("{\"jobs\"} ");

        // Largest size limit.
        drain();
        write_limit(SIZE_LIMIT_TOP);
        send_str("{\"jobs\":0}");

        // Random documents, with a new size limit every few documents.
        docs = 0;
        random_start = bytes_queued;
        while (bytes_queued - random_start < RANDOM_BYTES || docs < RANDOM_DOCS) begin
            if (docs % DOCS_PER_LIMIT == 0) begin
                drain();
                write_limit(pick_limit());
            end
            make_random_doc();
            commit_doc();
            docs++;
        end
        drain();

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== json_structure_prechecker_core.f =====
rtl/core/jsp_pkg.sv
rtl/core/jsp_front.sv
rtl/core/jsp_tok_fifo.sv
rtl/core/jsp_back.sv
rtl/core/json_structure_prechecker_core.sv
tb/sv/json_structure_prechecker_core_test.sv
